/* design/shs_pkg.sv */
// shared types, constants and round functions for the sha-256 stream hasher
package shs_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN  = 6'd56;
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [2:0] WORD_LAST = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       eom;
  } shs_item_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_COMP = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_PAD  = 5'b01000,
    ST_OUT  = 5'b10000
  } shs_state_t;

  typedef enum logic [2:0] {
    PH_MARK = 3'b001,
    PH_ZERO = 3'b010,
    PH_LEN  = 3'b100
  } shs_phase_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* design/sha256_stream_hasher_core.sv */
// top level of the sha-256 stream hasher
//   input channel: each transaction carries one optional message byte
//   (in_byte_valid) and an optional end mark (in_end_of_message); it is taken
//   at a clock edge with push high and full low
//   result channel: eight transactions per message, digest words H0..H7 with
//   their index and a last flag on H7; the word is on the ports while empty
//   is low and is taken at an edge with pop high
// processing
//   while idle, the back end takes one queued item at a time; each full
//   64-byte block halts intake for 64 rounds at one round per cycle on
//   the shared round logic and a step folding the result into the chaining
//   value; at the end mark, padding appends 9 to 72 pad bytes and takes
//   one or two block compressions, then the digest words follow, one per
//   cycle while pop is high
// queueing
//   a short item queue sits between the front and the back end, so input is
//   taken while a block compresses or while digest words wait; when the
//   receiver stalls the digest holds and the queue fills, then full rises
// reset: synchronous, active low; the queue empties, the chaining value
//   returns to the initial hash values and byte and length counters clear
module sha256_stream_hasher_core #(
  parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import shs_pkg::*;

  // queue head toward the back end
  shs_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  shs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_byte_valid    (in_byte_valid),
    .in_end_of_message(in_end_of_message),
    .q_item           (q_item),
    .q_valid          (q_valid),
    .q_pop            (q_pop)
  );

  // block assembly, padding, compression and digest readout
  shs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

endmodule

/* design/shs_front.sv */
// front end: input handshake, drop of empty items, item queue toward the back end
module shs_front #(
  parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_byte_valid,
  input  logic              in_end_of_message,
  output shs_pkg::shs_item_t q_item,
  output logic              q_valid,
  input  logic              q_pop
);
  import shs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  shs_item_t     mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          wr_en;
  logic          rd_en;

  assign full    = (cnt_r == CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  // items with neither a byte nor an end mark change nothing, so they are dropped here
  assign wr_en = push && !full && (in_byte_valid || in_end_of_message);
  assign rd_en = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= '{data: in_data_byte, byte_valid: in_byte_valid,
                           eom: in_end_of_message};
    end
  end

endmodule

/* design/shs_back.sv */
// back end: block assembly, padding, round-per-cycle compression, digest readout
module shs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  shs_pkg::shs_item_t q_item,
  input  logic               q_valid,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);
  import shs_pkg::*;

  shs_state_t  state_r, state_nxt;
  shs_state_t  ret_r, ret_nxt;
  shs_phase_t  phase_r, phase_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] len_r, len_nxt;
  logic [2:0]  lidx_r, lidx_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  widx_r, widx_nxt;
  logic [511:0] blk_r, blk_nxt;
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];

  logic        push_en;
  logic [7:0]  push_byte;
  logic [63:0] len_bits;
  logic [63:0] len_shift;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign len_bits  = {len_r, 3'b000};
  assign len_shift = len_bits >> {~lidx_r, 3'b000};

  // schedule word for the window slot that opens as the oldest word leaves
  assign w_new = small_sigma1(blk_r[63:32]) + blk_r[223:192] +
                 small_sigma0(blk_r[479:448]) + blk_r[511:480];

  assign t1 = v_r[7] + big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) +
              ROUND_K[rnd_r] + blk_r[511:480];
  assign t2 = big_sigma0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign empty           = (state_r != ST_OUT);
  assign out_digest_word = h_r[widx_r];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == WORD_LAST);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    lidx_nxt  = lidx_r;
    rnd_nxt   = rnd_r;
    widx_nxt  = widx_r;
    blk_nxt   = blk_r;
    v_nxt     = v_r;
    h_nxt     = h_r;
    push_en   = 1'b0;
    push_byte = '0;
    q_pop     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.byte_valid) begin
            push_en   = 1'b1;
            push_byte = q_item.data;
            len_nxt   = len_r + 1'b1;
          end
          if (q_item.eom) begin
            state_nxt = ST_PAD;
            phase_nxt = PH_MARK;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        unique case (phase_r)
          PH_MARK: begin
            push_byte = PAD_MARK;
            phase_nxt = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill_r == FILL_LEN) begin
              push_byte = len_bits[63:56];
              phase_nxt = PH_LEN;
              lidx_nxt  = 3'd1;
            end
          end
          PH_LEN: begin
            push_byte = len_shift[7:0];
            lidx_nxt  = lidx_r + 1'b1;
            if (lidx_r == WORD_LAST) begin
              state_nxt = ST_OUT;
            end
          end
          default: begin
            phase_nxt = PH_MARK;
          end
        endcase
      end
      ST_COMP: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        blk_nxt  = {blk_r[479:0], w_new};
        rnd_nxt  = rnd_r + 1'b1;
        if (rnd_r == FILL_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (pop) begin
          widx_nxt = widx_r + 1'b1;
          if (widx_r == WORD_LAST) begin
            h_nxt     = INIT_H;
            len_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // common byte push; a full block diverts to compression and then resumes
    if (push_en) begin
      blk_nxt  = {blk_r[503:0], push_byte};
      fill_nxt = fill_r + 1'b1;
      if (fill_r == FILL_LAST) begin
        ret_nxt   = state_nxt;
        state_nxt = ST_COMP;
        rnd_nxt   = '0;
        v_nxt     = h_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      phase_r <= PH_MARK;
      fill_r  <= '0;
      len_r   <= '0;
      lidx_r  <= '0;
      rnd_r   <= '0;
      widx_r  <= '0;
      h_r     <= INIT_H;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      lidx_r  <= lidx_nxt;
      rnd_r   <= rnd_nxt;
      widx_r  <= widx_nxt;
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    v_r   <= v_nxt;
  end

endmodule

/* design/shs_checker.sv */
// port-level checks on the digest readout of the sha-256 stream hasher
module shs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);
  import shs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result channel not empty after reset");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_last_word == (out_word_index == WORD_LAST)))
    else $error("last flag does not match word index");

  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> (out_word_index == 3'd0))
    else $error("digest does not start at word zero");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last_word) |=>
      (!empty && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest word index did not advance");

  a_digest_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_last_word) |=> empty)
    else $error("results continue past the last digest word");

endmodule

bind sha256_stream_hasher_core shs_checker u_shs_checker (.*);

/* dv/sha256_digest_checker.sv */
// digest predictor and result checker for the sha-256 stream hasher
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         REPORT_MAX = 10;
  localparam int         LEN_SLOT   = 56;
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [2:0] LAST_INDEX = 3'd7;

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_rec_t;

  logic [31:0] chain_h [8];
  logic [7:0]  blk_bytes [64];
  int          fill;
  logic [60:0] msg_len;
  digest_rec_t expected_words [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    blk_bytes[fill] = b;
    fill++;
    if (fill == 64) begin
      compress_block();
      fill = 0;
    end
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain_h[i] = IV_WORDS[i];
    fill    = 0;
    msg_len = '0;
  endfunction

  // one accepted input transaction; an end mark pads and queues eight words
  function automatic void predict_digest(input logic [7:0] data, input logic bv,
                                         input logic eom);
    logic [63:0] len_bits;
    digest_rec_t rec;
    if (bv) begin
      absorb_byte(data);
      msg_len = msg_len + 61'd1;
    end
    if (eom) begin
      len_bits = {msg_len, 3'b000};
      absorb_byte(PAD_BYTE);
      while (fill != LEN_SLOT) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len_bits[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        rec.word  = chain_h[i];
        rec.index = i[2:0];
        rec.last  = (i[2:0] == LAST_INDEX);
        expected_words.push_back(rec);
      end
      restart_message();
    end
  endfunction

  task automatic report_mismatch(input digest_rec_t want, input digest_rec_t got,
                                 input bit have_want);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      if (have_want)
        $display("digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
                 want.word, want.index, want.last, got.word, got.index, got.last);
      else
        $display("unexpected digest word %h index %0d last %b", got.word, got.index,
                 got.last);
    end
  endtask

  always @(posedge clk) begin
    digest_rec_t got;
    digest_rec_t want;
    if (!rst_n) begin
      restart_message();
      expected_words.delete();
    end else begin
      // compare first: a result at this edge never comes from this edge's item
      if (pop && !empty) begin
        got = '{out_digest_word, out_word_index, out_last_word};
        if (expected_words.size() == 0) begin
          report_mismatch(got, got, 1'b0);
        end else begin
          want = expected_words.pop_front();
          if (got.word !== want.word || got.index !== want.index || got.last !== want.last)
            report_mismatch(want, got, 1'b1);
        end
      end
      if (push && !full) predict_digest(in_data_byte, in_byte_valid, in_end_of_message);
    end
    pending = expected_words.size();
  end

endmodule

/* dv/testbench.sv */
// stimulus, clock, reset and verdict for the sha-256 stream hasher
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // watchdog: cycles without any accepted transaction
  localparam int STALL_LIMIT  = 4000;
  // long receiver hold-off that makes the item queue fill and raise full
  localparam int CHOKE_CYCLES = 400;
  // extra cycles after the last expected word, to catch stray results
  localparam int DRAIN_CYCLES = 300;
  // random part stops once this many items went in, directed ones included
  localparam int ITEM_TARGET  = 210;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_byte_valid;
  logic        in_end_of_message;
  logic        empty;
  logic        pop;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int fail_count;
  int pending;
  int items_sent;
  int stall_cycles;
  bit choke_req;
  bit choke_done;

  // boundary lengths around the one-block / two-block padding split
  int edge_lengths [9] = '{0, 1, 55, 56, 57, 63, 64, 65, 120};

  sha256_stream_hasher_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .empty             (empty),
    .pop               (pop),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  sha256_digest_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .empty             (empty),
    .pop               (pop),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // gap lengths: mostly none or short, now and then a long one
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(input logic [7:0] data, input logic bv, input logic eom);
    push              <= 1'b1;
    in_data_byte      <= data;
    in_byte_valid     <= bv;
    in_end_of_message <= eom;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // push drops only when a real gap follows, so back-to-back items keep it high
  task automatic idle_for(input int n);
    if (n > 0) begin
      push          <= 1'b0;
      in_data_byte  <= 8'($urandom);
      in_byte_valid <= 1'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // one message with random bytes; noise items (no byte, no end) mixed in
  task automatic send_message(input int len, input bit split_end, input bit no_idle);
    for (int i = 0; i < len; i++) begin
      if (!no_idle) idle_for(rand_gap());
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !split_end);
    end
    // empty message or a separate end mark with no byte
    if (len == 0 || split_end) begin
      if (!no_idle) idle_for(rand_gap());
      send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // stimulus
  initial begin
    int r;
    int len;
    rst_n             <= 1'b0;
    push              <= 1'b0;
    in_data_byte      <= 8'h00;
    in_byte_valid     <= 1'b0;
    in_end_of_message <= 1'b0;
    items_sent = 0;
    choke_req  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, with a stale data byte that must be ignored
    send_item(8'h5a, 1'b0, 1'b1);
    // items with neither byte nor end change nothing
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    // "abc"
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // single-byte messages at the byte extremes
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    // bytes then an end mark without a byte, an ignored item in between
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b1);
    // two empty messages back to back
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    idle_for(2);

    // random part; the receiver starts with its long hold-off
    choke_req  = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        len = $urandom_range(0, 12);
      else if (r < 70)
        len = edge_lengths[$urandom_range(0, 8)];
      else
        len = $urandom_range(0, 70);
      send_message(len, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) idle_for(rand_gap());
    end
    push <= 1'b0;
    // let the checker see the last accepted item
    @(posedge clk);

    // let every expected digest word come out, then watch for strays
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: random pop bursts and stalls, one long hold-off on request
  initial begin
    int n;
    pop        <= 1'b0;
    choke_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (choke_req && !choke_done) begin
        choke_done = 1'b1;
        pop <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        n = rand_gap();
        if (n > 0) begin
          pop <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // watchdog: any accepted transaction on either side counts as progress
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
